### rtl/dst_pkg.sv
`default_nettype none
package dst_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_OUT_W = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/dedup_set_table.sv
// Set of up to 64 distinct signed 32-bit values kept in insertion order in a
// single-port-read entry RAM. An insert (kind 0) appends a value not yet
// present, or flags overflow and drops it when the table is full; a query
// (kind 1) only reports presence. One item is worked at a time; the linear
// search, which ends early when a match is found, reads one stored entry per
// cycle through the RAM read port. The result register frees the input side,
// so the next item is taken while a result waits. The count resets to zero; no
// RAM clearing is needed.
`default_nettype none
module dedup_set_table
    import dst_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic                     i_kind,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      logic                     o_found,
    output      logic                     o_stored,
    output      logic                     o_overflow,
    output      logic [COUNT_OUT_W-1:0]   o_entry_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dst_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_kind),
        .i_item_value  (i_item_value),
        .o_found       (o_found),
        .o_stored      (o_stored),
        .o_overflow    (o_overflow),
        .o_entry_count (o_entry_count)
    );

endmodule
`default_nettype wire

### rtl/dst_ram.sv
`default_nettype none
module dst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/dst_ctrl.sv
`default_nettype none
module dst_ctrl
    import dst_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output      logic    o_in_ready,
    output      logic    o_out_valid,
    input  wire logic    i_out_ready,
    output      t_dp_cmd o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state       = r_state;
        n_out_vld     = r_out_vld && !i_out_ready;
        o_cmd.load    = 1'b0;
        o_cmd.search  = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_vld || i_out_ready))
        else $error("result overwritten before transfer");

    a_finish_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> ($past(r_state) == ST_SEARCH || $past(r_state) == ST_FINISH))
        else $error("finish entered without search");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_SEARCH))
        else $error("load did not start search");

endmodule
`default_nettype wire

### rtl/dst_datapath.sv
`default_nettype none
module dst_datapath
    import dst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output      t_dp_sts                 o_sts,
    input  wire logic                    i_kind,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    output      logic                    o_found,
    output      logic                    o_stored,
    output      logic                    o_overflow,
    output      logic [COUNT_OUT_W-1:0]  o_entry_count
);

    logic              r_kind;
    logic [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic              r_found;
    logic              r_out_found;
    logic              r_out_stored;
    logic              r_out_overflow;
    logic [DATA_W-1:0] rd_data;
    logic              hit_now;
    logic              rd_issue;
    logic              is_new;
    logic              wr_en;
    logic              full;

    assign hit_now  = r_rd_vld && (rd_data == r_value);
    assign rd_issue = i_cmd.search && !hit_now && !r_found && (r_idx < r_count);
    assign o_sts.done = hit_now || r_found || (!r_rd_vld && !(r_idx < r_count));
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign is_new   = (r_kind == KIND_INSERT) && !r_found;
    assign wr_en    = i_cmd.commit && is_new && !full;

    dst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.search) begin
                r_rd_vld <= rd_issue;
                r_found  <= r_found || hit_now;
                if (rd_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_item_value;
        end
        if (i_cmd.commit) begin
            r_out_found    <= r_found;
            r_out_stored   <= is_new && !full;
            r_out_overflow <= is_new && full;
        end
    end

    assign o_found       = r_out_found;
    assign o_stored      = r_out_stored;
    assign o_overflow    = r_out_overflow;
    assign o_entry_count = COUNT_OUT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("search index past last entry");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(wr_en))
        else $error("count changed without a write");

    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.commit) |-> $countones({r_out_found, r_out_stored, r_out_overflow}) <= 1)
        else $error("conflicting result flags");

endmodule
`default_nettype wire
